### rtl/core/irpwd_pkg.sv
package irpwd_pkg;

   localparam int MSG_BYTES_DEF = 12;
   localparam int CRC_SPAN_DEF  = 10;

   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int SAMPLE_W  = 16;
   localparam int INDEX_W   = 4;
   localparam int CRC_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_FLOOR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_GAP       = 3'd4;

   localparam logic [CFG_W-1:0] IDLE_LOW_RST      = 8'd50;
   localparam logic [CFG_W-1:0] PREAMBLE_HIGH_RST = 8'd40;
   localparam logic [CFG_W-1:0] ZERO_FLOOR_RST    = 8'd3;
   localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 8'd10;
   localparam logic [CFG_W-1:0] END_GAP_RST       = 8'd40;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ARMED  = 2'd1,
      MODE_DECODE = 2'd2
   } mode_type;

endpackage

### rtl/core/ir_pulse_width_message_decoder_core.sv
// Pulse-width IR message decoder with a CRC-16/XMODEM check.
// The request channel (req_valid, req_ready, req_sample) takes one signed
// sample per request; only its sign and whether it is nonzero are used. An
// ordinary sample leaves the block idle, so it is ready for the next one.
// A sample that ends a message with the full byte count starts a burst: the
// CRC shifter runs one bit per cycle over the first CRC_SPAN stored bytes,
// the two bytes after them are compared with it, and each of the MSG_BYTES
// result bytes is sent, waiting on rsp_ready. No request is taken in a burst.
// A sample that completes one byte too many gives a single format-error
// result with kind set and last high. Results leave from an output register on
// the rsp_ channel; while rsp_ready is low the result is held and the block
// takes no new request. The csr_ port writes the five threshold registers;
// the user must use it only while idle, which the block does not enforce.
// Reset is synchronous and active high; it restores the register defaults and
// clears the run counters and the decoder mode. The message store needs no
// clearing pass because every byte is written whole before it is read.
module ir_pulse_width_message_decoder_core #(
   parameter int MSG_BYTES = irpwd_pkg::MSG_BYTES_DEF,
   parameter int CRC_SPAN  = irpwd_pkg::CRC_SPAN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [irpwd_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [irpwd_pkg::INDEX_W-1:0]       rsp_byte_index,
   output logic [irpwd_pkg::CFG_W-1:0]         rsp_byte_value,
   output logic                                rsp_crc_good,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [irpwd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [irpwd_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int IDX_W  = $clog2(MSG_BYTES);
   localparam int CNT_W  = $clog2(MSG_BYTES + 1);
   localparam int SPAN_N = (CRC_SPAN < MSG_BYTES) ? CRC_SPAN : MSG_BYTES;
   localparam bit HI_IN  = (CRC_SPAN < MSG_BYTES);
   localparam bit LO_IN  = (CRC_SPAN + 1 < MSG_BYTES);
   localparam logic [IDX_W-1:0] HI_ADDR = IDX_W'(HI_IN ? CRC_SPAN : 0);
   localparam logic [IDX_W-1:0] LO_ADDR = IDX_W'(LO_IN ? CRC_SPAN + 1 : 0);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MSG_BYTES);
   localparam logic [CNT_W-1:0] SPAN_COUNT = CNT_W'(SPAN_N);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(MSG_BYTES - 1);
   localparam int W = irpwd_pkg::CFG_W;
   localparam int C = irpwd_pkg::CRC_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CRC_LOAD,
      S_CRC_XOR,
      S_CRC_SHIFT,
      S_HI_LOAD,
      S_HI_TAKE,
      S_LO_LOAD,
      S_LO_TAKE,
      S_EMIT_LOAD,
      S_EMIT_TAKE,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [W-1:0]          idle_low_ff, idle_low_in;
   logic [W-1:0]          pre_high_ff, pre_high_in;
   logic [W-1:0]          zero_floor_ff, zero_floor_in;
   logic [W-1:0]          one_thr_ff, one_thr_in;
   logic [W-1:0]          end_gap_ff, end_gap_in;
   logic [W-1:0]          high_run_ff, high_run_in;
   logic [W-1:0]          low_run_ff, low_run_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [CNT_W-1:0]      byte_count_ff, byte_count_in;
   logic [2:0]            bit_pos_ff, bit_pos_in;
   irpwd_pkg::mode_type   mode_ff, mode_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [2:0]            bit_cnt_ff, bit_cnt_in;
   logic [C-1:0]          crc_ff, crc_in;
   logic [W-1:0]          rcv_hi_ff, rcv_hi_in;
   logic                  good_ff, good_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [irpwd_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [W-1:0]          rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [W-1:0]          mem [MSG_BYTES];
   logic [W-1:0]          rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [W-1:0]          mem_wdata;

   logic                  accept;
   logic                  pos;
   logic                  neg;
   logic [W-1:0]          low_inc;
   logic                  bit_zero;
   logic                  bit_one;
   logic [W-1:0]          acc_next;
   logic [C-1:0]          crc_shift;

   assign req_ready      = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept         = req_valid && req_ready;
   assign pos            = (req_sample != '0) && !req_sample[irpwd_pkg::SAMPLE_W-1];
   assign neg            = req_sample[irpwd_pkg::SAMPLE_W-1];
   assign low_inc        = (low_run_ff == '1) ? low_run_ff : low_run_ff + 1'b1;
   assign bit_zero       = (high_run_ff > zero_floor_ff) && (high_run_ff < one_thr_ff);
   assign bit_one        = (high_run_ff > one_thr_ff);
   assign acc_next       = {acc_ff[W-2:0], bit_one};
   assign crc_shift      = crc_ff[C-1] ? ({crc_ff[C-2:0], 1'b0} ^ irpwd_pkg::CRC_POLY)
                                       : {crc_ff[C-2:0], 1'b0};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_byte_value = rsp_value_ff;
   assign rsp_crc_good   = good_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      case (state_ff)
         S_HI_LOAD: begin
            rd_addr = HI_ADDR;
         end
         S_LO_LOAD: begin
            rd_addr = LO_ADDR;
         end
         default: begin
            rd_addr = idx_ff[IDX_W-1:0];
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idle_low_in   = idle_low_ff;
      pre_high_in   = pre_high_ff;
      zero_floor_in = zero_floor_ff;
      one_thr_in    = one_thr_ff;
      end_gap_in    = end_gap_ff;
      high_run_in   = high_run_ff;
      low_run_in    = low_run_ff;
      acc_in        = acc_ff;
      byte_count_in = byte_count_ff;
      bit_pos_in    = bit_pos_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      bit_cnt_in    = bit_cnt_ff;
      crc_in        = crc_ff;
      rcv_hi_in     = rcv_hi_ff;
      good_in       = good_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = byte_count_ff[IDX_W-1:0];
      mem_wdata     = acc_next;

      if (csr_we) begin
         case (csr_index)
            irpwd_pkg::CSR_IDLE_LOW: begin
               idle_low_in = csr_wdata;
            end
            irpwd_pkg::CSR_PREAMBLE_HIGH: begin
               pre_high_in = csr_wdata;
            end
            irpwd_pkg::CSR_ZERO_FLOOR: begin
               zero_floor_in = csr_wdata;
            end
            irpwd_pkg::CSR_ONE_THRESHOLD: begin
               one_thr_in = csr_wdata;
            end
            irpwd_pkg::CSR_END_GAP: begin
               end_gap_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && pos) begin
               high_run_in = (high_run_ff == '1) ? high_run_ff : high_run_ff + 1'b1;
               low_run_in  = '0;
            end else if (accept && neg && (high_run_ff != '0)) begin
               high_run_in = '0;
               low_run_in  = low_inc;
               if (mode_ff == irpwd_pkg::MODE_ARMED) begin
                  if (high_run_ff > pre_high_ff) begin
                     mode_in = irpwd_pkg::MODE_DECODE;
                  end else begin
                     low_run_in = '0;
                     mode_in    = irpwd_pkg::MODE_IDLE;
                  end
               end else if ((mode_ff == irpwd_pkg::MODE_DECODE) && (bit_zero || bit_one)) begin
                  acc_in = acc_next;
                  if (bit_pos_ff == 3'd7) begin
                     bit_pos_in = '0;
                     if (byte_count_ff == FULL_COUNT) begin
                        low_run_in    = '0;
                        byte_count_in = '0;
                        mode_in       = irpwd_pkg::MODE_IDLE;
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = irpwd_pkg::KIND_ERROR;
                        rsp_index_in  = '0;
                        rsp_value_in  = '0;
                        good_in       = 1'b0;
                        rsp_last_in   = 1'b1;
                        state_in      = S_EMIT;
                     end else begin
                        mem_we        = 1'b1;
                        byte_count_in = byte_count_ff + 1'b1;
                     end
                  end else begin
                     bit_pos_in = bit_pos_ff + 1'b1;
                  end
               end
            end else if (accept && neg) begin
               low_run_in = low_inc;
               if ((mode_ff == irpwd_pkg::MODE_IDLE) && (low_inc > idle_low_ff)) begin
                  mode_in = irpwd_pkg::MODE_ARMED;
               end else if ((mode_ff == irpwd_pkg::MODE_DECODE) && (low_inc > end_gap_ff)) begin
                  if ((byte_count_ff == FULL_COUNT) && (bit_pos_ff == '0)) begin
                     idx_in   = '0;
                     crc_in   = '0;
                     state_in = S_CRC_LOAD;
                  end
                  low_run_in    = '0;
                  byte_count_in = '0;
                  bit_pos_in    = '0;
                  mode_in       = irpwd_pkg::MODE_IDLE;
               end
            end
         end
         S_CRC_LOAD: begin
            state_in = S_CRC_XOR;
         end
         S_CRC_XOR: begin
            crc_in     = crc_ff ^ {rd_data_ff, 8'h00};
            bit_cnt_in = '0;
            state_in   = S_CRC_SHIFT;
         end
         S_CRC_SHIFT: begin
            crc_in     = crc_shift;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == 3'd7) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == SPAN_COUNT) begin
                  state_in = S_HI_LOAD;
               end else begin
                  state_in = S_CRC_LOAD;
               end
            end
         end
         S_HI_LOAD: begin
            state_in = S_HI_TAKE;
         end
         S_HI_TAKE: begin
            rcv_hi_in = HI_IN ? rd_data_ff : '0;
            state_in  = S_LO_LOAD;
         end
         S_LO_LOAD: begin
            state_in = S_LO_TAKE;
         end
         S_LO_TAKE: begin
            good_in  = (crc_ff == {rcv_hi_ff, (LO_IN ? rd_data_ff : 8'h00)});
            idx_in   = '0;
            state_in = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            state_in = S_EMIT_TAKE;
         end
         S_EMIT_TAKE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = irpwd_pkg::KIND_BYTE;
            rsp_index_in = irpwd_pkg::INDEX_W'(idx_ff);
            rsp_value_in = rd_data_ff;
            rsp_last_in  = (idx_ff == LAST_COUNT);
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_EMIT_LOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idle_low_ff   <= irpwd_pkg::IDLE_LOW_RST;
         pre_high_ff   <= irpwd_pkg::PREAMBLE_HIGH_RST;
         zero_floor_ff <= irpwd_pkg::ZERO_FLOOR_RST;
         one_thr_ff    <= irpwd_pkg::ONE_THRESHOLD_RST;
         end_gap_ff    <= irpwd_pkg::END_GAP_RST;
         high_run_ff   <= '0;
         low_run_ff    <= '0;
         byte_count_ff <= '0;
         bit_pos_ff    <= '0;
         mode_ff       <= irpwd_pkg::MODE_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idle_low_ff   <= idle_low_in;
         pre_high_ff   <= pre_high_in;
         zero_floor_ff <= zero_floor_in;
         one_thr_ff    <= one_thr_in;
         end_gap_ff    <= end_gap_in;
         high_run_ff   <= high_run_in;
         low_run_ff    <= low_run_in;
         byte_count_ff <= byte_count_in;
         bit_pos_ff    <= bit_pos_in;
         mode_ff       <= mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      idx_ff       <= idx_in;
      bit_cnt_ff   <= bit_cnt_in;
      crc_ff       <= crc_in;
      rcv_hi_ff    <= rcv_hi_in;
      good_ff      <= good_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
